// ===== design/bokl_pkg.sv =====
// ----------------------------------------------------------------------------
// bokl_pkg
// Shared constants, codes and types for the bounded ordered key list.
// ----------------------------------------------------------------------------
package bokl_pkg;

   localparam int MAX_ENTRIES = 16;
   localparam int KEY_BITS    = 16;

   // Internal widths
   localparam int COUNT_W = $clog2(MAX_ENTRIES + 1);
   localparam int IDX_W   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

   // Fixed field widths
   localparam int CAP_BITS    = 5;
   localparam int OP_BITS     = 2;
   localparam int STATUS_BITS = 2;
   localparam int POS_BITS    = 4;
   localparam int CNT_BITS    = 5;

   localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(16);

   typedef enum logic [OP_BITS-1:0] {
      OP_APPEND     = 2'd0,
      OP_POP_HEAD   = 2'd1,
      OP_SEARCH     = 2'd2,
      OP_REMOVE_KEY = 2'd3
   } op_type;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_OK        = 2'd0,
      ST_FULL      = 2'd1,
      ST_EMPTY     = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

   // Per-cell control from the list controller
   typedef struct packed {
      logic occupied;  // slot holds a live entry
      logic load;      // write the request key into this slot
      logic pop;       // shift toward head unconditionally
      logic remove;    // shift toward head at and after the first match
   } cell_ctrl_type;

   // Clamp the capacity register into 1..MAX_ENTRIES
   function automatic logic [COUNT_W-1:0] effective_cap(input logic [CAP_BITS-1:0] cap);
      logic [COUNT_W-1:0] result;
      if (cap == '0) begin
         result = COUNT_W'(1);
      end else if (int'(cap) > MAX_ENTRIES) begin
         result = COUNT_W'(MAX_ENTRIES);
      end else begin
         result = COUNT_W'(cap);
      end
      return result;
   endfunction

endpackage

// ===== design/bokl_cell.sv =====
// ----------------------------------------------------------------------------
// bokl_cell
// One list slot: holds a key, compares it, loads or shifts from its neighbor.
// ----------------------------------------------------------------------------
module bokl_cell (
   input  logic                           clock,
   input  bokl_pkg::cell_ctrl_type        ctrl,
   input  logic [bokl_pkg::KEY_BITS-1:0]  cmp_key,
   input  logic [bokl_pkg::KEY_BITS-1:0]  next_key,
   input  logic                           found_in,
   output logic [bokl_pkg::KEY_BITS-1:0]  key_q,
   output logic                           found_out,
   output logic                           first_hit
);

   logic [bokl_pkg::KEY_BITS-1:0] key_ff;
   logic [bokl_pkg::KEY_BITS-1:0] key_in;
   logic                          hit;
   logic                          shift;

   assign hit       = ctrl.occupied && (key_ff == cmp_key);
   assign found_out = found_in | hit;
   assign first_hit = hit & ~found_in;
   assign shift     = ctrl.pop | (ctrl.remove & found_out);

   always_comb begin
      if (shift) begin
         key_in = next_key;
      end else if (ctrl.load) begin
         key_in = cmp_key;
      end else begin
         key_in = key_ff;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

   assign key_q = key_ff;

endmodule

// ===== design/bounded_ordered_key_list_top.sv =====
// ----------------------------------------------------------------------------
// bounded_ordered_key_list_top
// Ordered key list with append, pop head, search and remove-by-key.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake            Payload
//  req_      in         req_valid/req_ready  req_op, req_key
//  rsp_      out        rsp_valid/rsp_ready  status, key_out, position,
//                                            entry_count, is_empty, is_full
//  csr_      in         csr_we (no wait)     csr_wdata = capacity limit
//
//  One transaction per cycle while rsp_ is taken: the result is formed in the
//  accepting cycle, loaded at the accepting edge and offered on rsp_ from there.
//  All slots compare in parallel; a removal shifts every slot from the first
//  match (the head for pop) to the tail by one in the same cycle.
//  req_ready is high while the response register is empty or being taken.
//  Synchronous reset empties the list, capacity 16; slots keep stale keys.
// ----------------------------------------------------------------------------
module bounded_ordered_key_list_top (
   input  logic                               clock,
   input  logic                               reset,
   // request
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [bokl_pkg::OP_BITS-1:0]       req_op,
   input  logic [bokl_pkg::KEY_BITS-1:0]      req_key,
   // response
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [bokl_pkg::STATUS_BITS-1:0]   rsp_status,
   output logic [bokl_pkg::KEY_BITS-1:0]      rsp_key_out,
   output logic [bokl_pkg::POS_BITS-1:0]      rsp_position,
   output logic [bokl_pkg::CNT_BITS-1:0]      rsp_entry_count,
   output logic                               rsp_is_empty,
   output logic                               rsp_is_full,
   // configuration
   input  logic                               csr_we,
   input  logic [bokl_pkg::CAP_BITS-1:0]      csr_wdata
);

   localparam int N  = bokl_pkg::MAX_ENTRIES;
   localparam int KW = bokl_pkg::KEY_BITS;
   localparam int CW = bokl_pkg::COUNT_W;
   localparam int IW = bokl_pkg::IDX_W;

   // Control state
   logic [bokl_pkg::CAP_BITS-1:0] cap_ff;
   logic [CW-1:0]                 count_ff;
   logic [CW-1:0]                 count_in;
   logic                          rsp_valid_ff;

   // Response payload
   logic [bokl_pkg::STATUS_BITS-1:0] status_ff, status_in;
   logic [KW-1:0]                    key_out_ff, key_out_in;
   logic [bokl_pkg::POS_BITS-1:0]    pos_ff, pos_in;
   logic [bokl_pkg::CNT_BITS-1:0]    cnt_ff;
   logic                             empty_ff, full_ff;

   logic                 accept;
   bokl_pkg::op_type     op;
   logic [CW-1:0]        cap_eff;
   logic                 is_empty_now;
   logic                 append_ok;
   logic                 pop_ok;
   logic                 remove_go;
   logic                 found_any;
   logic [IW-1:0]        hit_idx;
   logic [KW-1:0]        hit_key;

   // Cell chain wiring
   bokl_pkg::cell_ctrl_type cell_ctrl [N];
   logic [KW-1:0]           cell_key  [N];
   logic [KW-1:0]           cell_next [N];
   logic                    found     [N+1];
   logic                    first     [N];

   assign req_ready = ~rsp_valid_ff | rsp_ready;
   assign accept    = req_valid & req_ready;
   assign op        = bokl_pkg::op_type'(req_op);
   assign cap_eff   = bokl_pkg::effective_cap(cap_ff);

   assign is_empty_now = (count_ff == '0);
   assign append_ok    = accept && (op == bokl_pkg::OP_APPEND) && (count_ff < cap_eff);
   assign pop_ok       = accept && (op == bokl_pkg::OP_POP_HEAD) && !is_empty_now;
   // remove-by-key shifts only where a match exists, so no separate gate
   assign remove_go    = accept && (op == bokl_pkg::OP_REMOVE_KEY);

   assign found[0] = 1'b0;

   for (genvar g = 0; g < N; g++) begin : gen_cell
      assign cell_ctrl[g].occupied = (CW'(g) < count_ff);
      assign cell_ctrl[g].load     = append_ok && (count_ff == CW'(g));
      assign cell_ctrl[g].pop      = pop_ok;
      assign cell_ctrl[g].remove   = remove_go;

      // last slot recirculates its own key when shifting
      if (g == N - 1) begin : gen_tail
         assign cell_next[g] = cell_key[g];
      end else begin : gen_mid
         assign cell_next[g] = cell_key[g+1];
      end

      bokl_cell u_cell (
         .clock     (clock),
         .ctrl      (cell_ctrl[g]),
         .cmp_key   (req_key),
         .next_key  (cell_next[g]),
         .found_in  (found[g]),
         .key_q     (cell_key[g]),
         .found_out (found[g+1]),
         .first_hit (first[g])
      );
   end

   assign found_any = found[N];

   // One-hot first match to index and key
   always_comb begin
      hit_idx = '0;
      hit_key = '0;
      for (int i = 0; i < N; i++) begin
         if (first[i]) begin
            hit_idx = hit_idx | IW'(i);
            hit_key = hit_key | cell_key[i];
         end
      end
   end

   // Result and next count
   always_comb begin
      status_in  = bokl_pkg::ST_OK;
      key_out_in = '0;
      pos_in     = '0;
      count_in   = count_ff;
      case (op)
         bokl_pkg::OP_APPEND: begin
            if (count_ff >= cap_eff) begin
               status_in = bokl_pkg::ST_FULL;
            end else begin
               count_in = count_ff + CW'(1);
            end
         end
         bokl_pkg::OP_POP_HEAD: begin
            if (is_empty_now) begin
               status_in = bokl_pkg::ST_EMPTY;
            end else begin
               key_out_in = cell_key[0];
               count_in   = count_ff - CW'(1);
            end
         end
         bokl_pkg::OP_SEARCH: begin
            if (is_empty_now) begin
               status_in = bokl_pkg::ST_EMPTY;
            end else if (!found_any) begin
               status_in = bokl_pkg::ST_NOT_FOUND;
            end else begin
               pos_in = bokl_pkg::POS_BITS'(hit_idx);
            end
         end
         bokl_pkg::OP_REMOVE_KEY: begin
            if (is_empty_now) begin
               status_in = bokl_pkg::ST_EMPTY;
            end else if (!found_any) begin
               status_in = bokl_pkg::ST_NOT_FOUND;
            end else begin
               key_out_in = hit_key;
               count_in   = count_ff - CW'(1);
            end
         end
         default: begin
            status_in = bokl_pkg::ST_OK;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff       <= bokl_pkg::CAP_RESET;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            cap_ff <= csr_wdata;
         end
         if (accept) begin
            count_ff     <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload holds until the next accepted transaction
   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff  <= status_in;
         key_out_ff <= key_out_in;
         pos_ff     <= pos_in;
         cnt_ff     <= bokl_pkg::CNT_BITS'(count_in);
         empty_ff   <= (count_in == '0);
         full_ff    <= (count_in >= cap_eff);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_key_out     = key_out_ff;
   assign rsp_position    = pos_ff;
   assign rsp_entry_count = cnt_ff;
   assign rsp_is_empty    = empty_ff;
   assign rsp_is_full     = full_ff;

endmodule
